@@ rtl/sqs_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sqs_pkg
// Shared types and constants of the shift queue with search.
// ----------------------------------------------------------------------------
package sqs_pkg;

  localparam int unsigned VALUE_W = 32;
  localparam int unsigned OP_W    = 3;
  localparam int unsigned IDX_W   = 4;
  localparam int unsigned COUNT_W = 5;
  localparam int unsigned CAP_W   = 5;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  typedef enum logic [OP_W-1:0] {
    OP_ENQ  = 3'd0,
    OP_DEQ  = 3'd1,
    OP_PEEK = 3'd2,
    OP_CLR  = 3'd3,
    OP_SRCH = 3'd4
  } op_e;

  // controller to datapath
  typedef struct packed {
    logic idle;
    logic accept;
    logic step;
    logic finish;
  } sqs_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic done;
  } sqs_sts_t;

endpackage
`default_nettype wire

@@ rtl/sqs_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sqs_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module sqs_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

@@ rtl/sqs_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sqs_ctrl
// Controller: input/output handshakes and sequencing of one transaction.
// ----------------------------------------------------------------------------
module sqs_ctrl
  import sqs_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  wire logic     out_ready_i,
  input  wire sqs_sts_t sts_i,
  output sqs_cmd_t      cmd_o
);

  localparam logic [0:0] S_IDLE = 1'b0;
  localparam logic [0:0] S_BUSY = 1'b1;

  logic [0:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       slot_free;
  logic       busy;

  assign slot_free = !out_valid_q || out_ready_i;
  assign busy      = (state_q == S_BUSY);

  always_comb begin
    cmd_o.idle   = (state_q == S_IDLE);
    cmd_o.accept = cmd_o.idle && in_valid_i;
    cmd_o.step   = busy && !sts_i.done;
    cmd_o.finish = busy && sts_i.done && slot_free;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (cmd_o.accept) state_d = S_BUSY;
      end
      S_BUSY: begin
        if (cmd_o.finish) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign out_valid_d = cmd_o.finish || (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = cmd_o.idle;
  assign out_valid_o = out_valid_q;

  a_finish_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.finish |=> out_valid_q)
    else $error("result not presented after finish");

  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.accept |=> !in_ready_o)
    else $error("second transaction accepted while busy");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |-> !cmd_o.finish)
    else $error("pending result overwritten");

endmodule
`default_nettype wire

@@ rtl/sqs_dp.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sqs_dp
// Datapath: circular store, head and count, sequential search, result regs.
// ----------------------------------------------------------------------------
module sqs_dp
  import sqs_pkg::*;
#(
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire sqs_cmd_t                  cmd_i,
  output sqs_sts_t                       sts_o,
  input  wire logic [OP_W-1:0]           operation_i,
  input  wire logic signed [VALUE_W-1:0] value_i,
  input  wire logic                      cfg_we_i,
  input  wire logic [CAP_W-1:0]          cfg_wdata_i,
  output logic                           status_o,
  output logic signed [VALUE_W-1:0]      data_o,
  output logic [IDX_W-1:0]               found_index_o,
  output logic [COUNT_W-1:0]             count_o,
  output logic                           full_res_o,
  output logic                           empty_res_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned SW = AW + 1;
  localparam int unsigned XW = (CW > COUNT_W) ? CW : COUNT_W;

  localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);
  localparam logic [SW-1:0] DEPTH_S   = SW'(DEPTH);
  localparam logic [XW-1:0] DEPTH_X   = XW'(DEPTH);

  logic [AW-1:0]          head_q, head_d;
  logic [AW-1:0]          phys_q, phys_d;
  logic [CW-1:0]          count_q, count_d;
  logic [CW-1:0]          scan_q, scan_d;
  logic [CAP_W-1:0]       cap_q;
  logic [OP_W-1:0]        op_q;
  logic [VALUE_W-1:0]     value_q;

  logic                   status_q, status_d;
  logic [VALUE_W-1:0]     data_q, data_d;
  logic [IDX_W-1:0]       idx_q, idx_d;
  logic [COUNT_W-1:0]     cnt_res_q;
  logic                   full_q, empty_q;

  logic [VALUE_W-1:0]     rd_data;
  logic [AW-1:0]          raddr, waddr, head_next, phys_next;
  logic [SW-1:0]          wsum;
  logic [XW-1:0]          eff_cap, count_x, scan_x, count_d_x;
  logic                   enq_ok, nonempty, hit, scan_end, we;

  assign eff_cap  = (XW'(cap_q) < DEPTH_X) ? XW'(cap_q) : DEPTH_X;
  assign count_x  = XW'(count_q);
  assign scan_x   = XW'(scan_q);
  assign enq_ok   = count_x < eff_cap;
  assign nonempty = (count_q != '0);
  assign scan_end = (scan_q >= count_q);
  assign hit      = !scan_end && (rd_data == value_q);

  assign head_next = (head_q == LAST_ADDR) ? '0 : head_q + 1'b1;
  assign phys_next = (phys_q == LAST_ADDR) ? '0 : phys_q + 1'b1;
  assign wsum      = SW'(head_q) + SW'(count_q);
  assign waddr     = (wsum >= DEPTH_S) ? AW'(wsum - DEPTH_S) : AW'(wsum);
  assign raddr     = cmd_i.step ? phys_next : phys_q;

  assign sts_o.done = (op_q != OP_SRCH) || scan_end || hit;

  always_comb begin
    head_d   = head_q;
    count_d  = count_q;
    status_d = 1'b1;
    data_d   = '0;
    idx_d    = '0;
    we       = 1'b0;
    unique case (op_q)
      OP_ENQ: begin
        if (enq_ok) begin
          we       = 1'b1;
          count_d  = count_q + 1'b1;
          status_d = 1'b0;
        end
      end
      OP_DEQ: begin
        if (nonempty) begin
          data_d   = rd_data;
          head_d   = head_next;
          count_d  = count_q - 1'b1;
          status_d = 1'b0;
        end
      end
      OP_PEEK: begin
        if (nonempty) begin
          data_d   = rd_data;
          status_d = 1'b0;
        end
      end
      OP_CLR: begin
        count_d  = '0;
        status_d = 1'b0;
      end
      OP_SRCH: begin
        if (hit) begin
          idx_d    = scan_x[IDX_W-1:0];
          status_d = 1'b0;
        end
      end
      default: ;
    endcase
  end

  assign count_d_x = XW'(count_d);

  always_comb begin
    scan_d = scan_q;
    phys_d = phys_q;
    if (cmd_i.finish) begin
      scan_d = '0;
      phys_d = head_d;
    end else if (cmd_i.step) begin
      scan_d = scan_q + 1'b1;
      phys_d = phys_next;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      phys_q  <= '0;
      count_q <= '0;
      scan_q  <= '0;
      cap_q   <= CAP_RESET;
    end else begin
      scan_q <= scan_d;
      phys_q <= phys_d;
      if (cfg_we_i) begin
        cap_q   <= cfg_wdata_i;
        count_q <= '0;
      end else if (cmd_i.finish) begin
        head_q  <= head_d;
        count_q <= count_d;
      end
    end
  end

  // transaction payload and result registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      op_q    <= operation_i;
      value_q <= value_i;
    end
    if (cmd_i.finish) begin
      status_q  <= status_d;
      data_q    <= data_d;
      idx_q     <= idx_d;
      cnt_res_q <= count_d_x[COUNT_W-1:0];
      full_q    <= (count_d_x >= eff_cap);
      empty_q   <= (count_d == '0);
    end
  end

  sqs_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.finish && we),
    .waddr_i (waddr),
    .wdata_i (value_q),
    .raddr_i (raddr),
    .rdata_o (rd_data)
  );

  assign status_o      = status_q;
  assign data_o        = data_q;
  assign found_index_o = idx_q;
  assign count_o       = cnt_res_q;
  assign full_res_o    = full_q;
  assign empty_res_o   = empty_q;

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_x <= DEPTH_X)
    else $error("entry count above depth");

  a_idle_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.idle |-> (phys_q == head_q))
    else $error("read pointer off head while idle");

  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.step |-> (op_q == OP_SRCH) && !scan_end)
    else $error("search stepped past last entry");

endmodule
`default_nettype wire

@@ rtl/shift_queue_with_search.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// shift_queue_with_search
// FIFO of signed words, head at position 0, with enqueue, dequeue, peek,
// clear and search. One result transaction per input transaction.
//
// Input channel (in_valid_i/in_ready_o) carries operation_i and value_i.
// Output channel (out_valid_o/out_ready_i) carries status, data, index,
// count and the full/empty flags after the operation.
// One transaction is in flight at a time. For enqueue, dequeue, peek,
// clear and unknown codes the busy state finishes at once unless an
// earlier result still waits, and the result is then registered. A
// search reads one stored entry per cycle from the RAM read port and
// finishes on a match or after the last stored entry.
// The result sits in an output register; a new transaction is accepted
// while it waits. When the receiver stalls and a second result is ready,
// the block holds it internally and stops accepting until the register
// empties. Reset empties the queue and sets capacity to 16; no clearing
// pass is needed. Writing capacity (cfg_we_i) empties the queue.
// ----------------------------------------------------------------------------
module shift_queue_with_search
  import sqs_pkg::*;
#(
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      in_valid_i,
  output logic                           in_ready_o,
  input  wire logic [OP_W-1:0]           operation_i,
  input  wire logic signed [VALUE_W-1:0] value_i,
  output logic                           out_valid_o,
  input  wire logic                      out_ready_i,
  output logic                           status_o,
  output logic signed [VALUE_W-1:0]      data_o,
  output logic [IDX_W-1:0]               found_index_o,
  output logic [COUNT_W-1:0]             count_o,
  output logic                           full_res_o,
  output logic                           empty_res_o,
  input  wire logic                      cfg_we_i,
  input  wire logic [CAP_W-1:0]          cfg_wdata_i
);

  sqs_cmd_t cmd;
  sqs_sts_t sts;

  sqs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  sqs_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .operation_i   (operation_i),
    .value_i       (value_i),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .status_o      (status_o),
    .data_o        (data_o),
    .found_index_o (found_index_o),
    .count_o       (count_o),
    .full_res_o    (full_res_o),
    .empty_res_o   (empty_res_o)
  );

endmodule
`default_nettype wire
